FILE: rtl/first_fit_heap_allocator_top_defines.svh
// assertion macros for the allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTH
`define FFA_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define FFA_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define FFA_ASSERT_IMP(label, clk, rst_n, a, c)
`define FFA_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: rtl/ffa_pkg.sv
package ffa_pkg;
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_MAP    = 2'd1;
  localparam logic [1:0] OP_FREE   = 2'd2;
  localparam logic [1:0] OP_REINIT = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INVAL = 2'd1;
  localparam logic [1:0] ST_NOMEM = 2'd2;
  localparam logic [1:0] ST_NODES = 2'd3;

  localparam logic [2:0] CFG_H0_BASE = 3'd0;
  localparam logic [2:0] CFG_H0_SIZE = 3'd1;
  localparam logic [2:0] CFG_H1_BASE = 3'd2;
  localparam logic [2:0] CFG_H1_SIZE = 3'd3;
  localparam logic [2:0] CFG_H2_BASE = 3'd4;
  localparam logic [2:0] CFG_H2_SIZE = 3'd5;

  localparam logic [31:0] RST_BASE0 = 32'h0200_0000;
  localparam logic [31:0] RST_BASE1 = 32'h0300_0000;
  localparam logic [31:0] RST_BASE2 = 32'h0600_0000;
  localparam logic [18:0] RST_SIZE0 = 19'd245760;
  localparam logic [18:0] RST_SIZE1 = 19'h08000;
  localparam logic [18:0] RST_SIZE2 = 19'h18000;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_INIT   = 14'b00000000000010,
    S_RD     = 14'b00000000000100,
    S_WALK   = 14'b00000000001000,
    S_CHK    = 14'b00000000010000,
    S_UNLINK = 14'b00000000100000,
    S_SPLIT  = 14'b00000001000000,
    S_TRD    = 14'b00000010000000,
    S_TWALK  = 14'b00000100000000,
    S_MAPRD  = 14'b00001000000000,
    S_MAPW   = 14'b00010000000000,
    S_FREE   = 14'b00100000000000,
    S_FRW    = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_t;

  // descriptor store request
  typedef struct packed {
    logic        we_addr;
    logic        we_size;
    logic        we_link;
    logic [11:0] waddr;
    logic [31:0] wd_addr;
    logic [18:0] wd_size;
    logic [12:0] wd_link;
    logic [11:0] raddr;
  } mem_req_t;
endpackage

FILE: rtl/ffa_store.sv
module ffa_store #(
  parameter int NODES = 1024,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  ffa_pkg::mem_req_t req,
  output logic [31:0]       rd_addr,
  output logic [18:0]       rd_size,
  output logic [AW:0]       rd_link
);
  logic [31:0] addr_mem [NODES];
  logic [18:0] size_mem [NODES];
  logic [AW:0] link_mem [NODES];

  always_ff @(posedge clk) begin
    if (req.we_addr) addr_mem[req.waddr[AW-1:0]] <= req.wd_addr;
    if (req.we_size) size_mem[req.waddr[AW-1:0]] <= req.wd_size;
    if (req.we_link) link_mem[req.waddr[AW-1:0]] <= req.wd_link[AW:0];
    rd_addr <= addr_mem[req.raddr[AW-1:0]];
    rd_size <= size_mem[req.raddr[AW-1:0]];
    rd_link <= link_mem[req.raddr[AW-1:0]];
  end
endmodule

FILE: rtl/first_fit_heap_allocator_top.sv
// channel | valid    | stall     | payload
// in      | in_valid | in_stall  | in_op, in_heap_index, in_alloc_size, in_handle, ...
// out     | out_valid| out_stall | out_status, out_result_handle, out_address
// cfg     | cfg_we   | -         | cfg_index, cfg_data
// One word at a time. An allocation runs a fit search over the free list;
// a split remainder adds a tail search to append the remainder descriptor.
// The descriptor store has a single read port. Reset is synchronous: after
// it the heaps are rebuilt, with no word out.
// A stalled result holds the block until taken.
`include "first_fit_heap_allocator_top_defines.svh"
module first_fit_heap_allocator_top #(
  parameter int NODES = 1024,
  parameter int HEAPS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [1:0]  in_heap_index,
  input  logic [18:0] in_alloc_size,
  input  logic [9:0]  in_handle,
  input  logic [17:0] in_map_offset,
  input  logic [18:0] in_map_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [9:0]  out_result_handle,
  output logic [31:0] out_address,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int AW = $clog2(NODES);
  localparam logic [AW:0] NIL = (AW+1)'(NODES);

  ffa_pkg::state_t state_r, state_nxt;
  logic [31:0] base_r [3];
  logic [18:0] hsize_r [3];
  logic [AW:0] head_r [HEAPS];
  logic [AW:0] nextd_r, nextd_nxt;
  logic [AW:0] cur_r, cur_nxt, prev_r, prev_nxt, found_r, found_nxt;
  logic [AW:0] steps_r, steps_nxt;
  logic [1:0]  heap_r, heap_nxt, op_r;
  logic [18:0] want_r, msz_r;
  logic [17:0] off_r;
  logic [9:0]  hnd_r;
  logic [31:0] faddr_r, faddr_nxt;
  logic [18:0] fsize_r, fsize_nxt;
  logic [AW:0] flink_r, flink_nxt;
  logic [1:0]  st_r, st_nxt;
  logic [9:0]  rh_r, rh_nxt;
  logic [31:0] ad_r, ad_nxt;
  logic        ov_r, ov_nxt;
  logic [AW:0] head_wv;
  logic [1:0]  head_wi;
  logic        head_we;
  ffa_pkg::mem_req_t req;
  logic [31:0] rd_addr;
  logic [18:0] rd_size;
  logic [AW:0] rd_link;
  logic [18:0] rem;
  logic        hnd_bad;
  logic [1:0]  fheap;
  logic        fhit;
  logic [32:0] hi0, hi1, hi2;

  ffa_store #(.NODES(NODES), .AW(AW)) u_store (
    .clk(clk), .req(req), .rd_addr(rd_addr), .rd_size(rd_size), .rd_link(rd_link)
  );

  assign in_stall = (state_r != ffa_pkg::S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_result_handle = rh_r;
  assign out_address = ad_r;
  assign rem = fsize_r - want_r;
  assign hnd_bad = (32'(hnd_r) >= 32'(NODES));

  assign hi0 = {1'b0, base_r[0]} + 33'(hsize_r[0]);
  assign hi1 = {1'b0, base_r[1]} + 33'(hsize_r[1]);
  assign hi2 = {1'b0, base_r[2]} + 33'(hsize_r[2]);
  always_comb begin
    fhit = 1'b1;
    fheap = 2'd0;
    if (rd_addr >= base_r[0] && {1'b0, rd_addr} < hi0) fheap = 2'd0;
    else if (HEAPS > 1 && rd_addr >= base_r[1] && {1'b0, rd_addr} < hi1) fheap = 2'd1;
    else if (HEAPS > 2 && rd_addr >= base_r[2] && {1'b0, rd_addr} < hi2) fheap = 2'd2;
    else fhit = 1'b0;
  end

  always_comb begin
    state_nxt = state_r;
    nextd_nxt = nextd_r;
    cur_nxt = cur_r; prev_nxt = prev_r; found_nxt = found_r; steps_nxt = steps_r;
    heap_nxt = heap_r;
    faddr_nxt = faddr_r; fsize_nxt = fsize_r; flink_nxt = flink_r;
    st_nxt = st_r; rh_nxt = rh_r; ad_nxt = ad_r;
    ov_nxt = ov_r && out_stall;
    head_we = 1'b0; head_wi = heap_r; head_wv = NIL;
    req = '0;
    req.raddr = 12'(cur_r);
    case (state_r)
      ffa_pkg::S_IDLE: begin
        if (in_valid && !in_stall) begin
          st_nxt = ffa_pkg::ST_OK; rh_nxt = '0; ad_nxt = '0;
          heap_nxt = in_heap_index;
          req.raddr = 12'(in_handle);
          case (in_op)
            ffa_pkg::OP_ALLOC: begin
              if (32'(in_heap_index) >= 32'(HEAPS)) begin
                st_nxt = ffa_pkg::ST_INVAL; state_nxt = ffa_pkg::S_DONE;
              end else begin
                cur_nxt = head_r[in_heap_index[$clog2(HEAPS+1)-1:0]];
                prev_nxt = NIL; steps_nxt = '0; state_nxt = ffa_pkg::S_RD;
              end
            end
            ffa_pkg::OP_MAP:  state_nxt = ffa_pkg::S_MAPRD;
            ffa_pkg::OP_FREE: state_nxt = ffa_pkg::S_FREE;
            default: begin heap_nxt = 2'd0; state_nxt = ffa_pkg::S_INIT; end
          endcase
        end
      end
      ffa_pkg::S_INIT: begin
        req.we_addr = 1'b1; req.we_size = 1'b1; req.we_link = 1'b1;
        req.waddr = 12'(heap_r);
        req.wd_addr = base_r[heap_r]; req.wd_size = hsize_r[heap_r];
        req.wd_link = 13'(NIL);
        head_we = 1'b1; head_wv = (AW+1)'(heap_r);
        heap_nxt = heap_r + 2'd1;
        if (32'(heap_r) == HEAPS - 1) begin
          nextd_nxt = (AW+1)'(HEAPS);
          // rebuild after reset gives no word
          state_nxt = (op_r == ffa_pkg::OP_REINIT) ? ffa_pkg::S_DONE : ffa_pkg::S_IDLE;
        end
      end
      ffa_pkg::S_RD: begin
        if (cur_r >= NIL || steps_r == NIL) begin
          st_nxt = ffa_pkg::ST_NOMEM; state_nxt = ffa_pkg::S_DONE;
        end else state_nxt = ffa_pkg::S_WALK;
      end
      ffa_pkg::S_WALK: begin
        if (rd_size >= want_r) begin
          found_nxt = cur_r; faddr_nxt = rd_addr; fsize_nxt = rd_size; flink_nxt = rd_link;
          state_nxt = ffa_pkg::S_CHK;
        end else begin
          prev_nxt = cur_r; cur_nxt = rd_link; steps_nxt = steps_r + 1'b1;
          state_nxt = ffa_pkg::S_RD;
        end
      end
      ffa_pkg::S_CHK: begin
        if (rem != '0 && nextd_r >= NIL) begin
          st_nxt = ffa_pkg::ST_NODES; state_nxt = ffa_pkg::S_DONE;
        end else state_nxt = ffa_pkg::S_UNLINK;
      end
      ffa_pkg::S_UNLINK: begin
        if (prev_r == NIL) begin
          head_we = 1'b1; head_wv = flink_r;
        end else begin
          req.we_link = 1'b1; req.waddr = 12'(prev_r); req.wd_link = 13'(flink_r);
        end
        rh_nxt = 10'(found_r);
        state_nxt = ffa_pkg::S_SPLIT;
      end
      ffa_pkg::S_SPLIT: begin
        if (rem == '0) begin
          // found block: trim size, clear link
          req.we_link = 1'b1; req.we_size = 1'b1; req.waddr = 12'(found_r);
          req.wd_link = 13'(NIL); req.wd_size = want_r;
          state_nxt = ffa_pkg::S_DONE;
        end else begin
          // remainder descriptor goes in before the found block is trimmed
          req.we_addr = 1'b1; req.we_size = 1'b1; req.we_link = 1'b1;
          req.waddr = 12'(nextd_r);
          req.wd_addr = faddr_r + 32'(want_r); req.wd_size = rem;
          req.wd_link = 13'(NIL);
          state_nxt = ffa_pkg::S_MAPW;
        end
      end
      ffa_pkg::S_TRD: begin
        if (cur_r >= NIL) begin
          head_we = 1'b1; head_wv = nextd_r;
          nextd_nxt = nextd_r + 1'b1;
          state_nxt = ffa_pkg::S_DONE;
        end else state_nxt = ffa_pkg::S_TWALK;
      end
      ffa_pkg::S_TWALK: begin
        if (rd_link < NIL && steps_r != NIL) begin
          cur_nxt = rd_link; steps_nxt = steps_r + 1'b1; state_nxt = ffa_pkg::S_TRD;
        end else begin
          req.we_link = 1'b1; req.waddr = 12'(cur_r); req.wd_link = 13'(nextd_r);
          nextd_nxt = nextd_r + 1'b1;
          state_nxt = ffa_pkg::S_DONE;
        end
      end
      ffa_pkg::S_MAPW: begin
        if (op_r == ffa_pkg::OP_ALLOC) begin
          // found block: trim size, clear link, then find the tail
          req.we_link = 1'b1; req.we_size = 1'b1; req.waddr = 12'(found_r);
          req.wd_link = 13'(NIL); req.wd_size = want_r;
          cur_nxt = head_r[heap_r[$clog2(HEAPS+1)-1:0]];
          steps_nxt = (AW+1)'(1);
          state_nxt = ffa_pkg::S_TRD;
        end else begin
          if (hnd_bad) st_nxt = ffa_pkg::ST_INVAL;
          else begin
            ad_nxt = rd_addr + 32'(off_r);
            st_nxt = (msz_r > rd_size) ? ffa_pkg::ST_NOMEM : ffa_pkg::ST_OK;
          end
          state_nxt = ffa_pkg::S_DONE;
        end
      end
      ffa_pkg::S_MAPRD: state_nxt = ffa_pkg::S_MAPW;
      ffa_pkg::S_FREE: state_nxt = ffa_pkg::S_FRW;
      ffa_pkg::S_FRW: begin
        if (hnd_bad || !fhit) st_nxt = ffa_pkg::ST_INVAL;
        else begin
          req.we_link = 1'b1; req.waddr = 12'(hnd_r);
          req.wd_link = 13'(head_r[fheap[$clog2(HEAPS+1)-1:0]]);
          head_we = 1'b1; head_wi = fheap; head_wv = (AW+1)'(hnd_r);
        end
        state_nxt = ffa_pkg::S_DONE;
      end
      ffa_pkg::S_DONE: begin
        ov_nxt = 1'b1; state_nxt = ffa_pkg::S_IDLE;
      end
      default: state_nxt = ffa_pkg::S_IDLE;
    endcase
    if (state_r == ffa_pkg::S_MAPRD || state_r == ffa_pkg::S_FREE ||
        state_r == ffa_pkg::S_MAPW || state_r == ffa_pkg::S_FRW)
      req.raddr = 12'(hnd_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffa_pkg::S_INIT;
      heap_r <= 2'd0;
      ov_r <= 1'b0;
      op_r <= ffa_pkg::OP_ALLOC;
      nextd_r <= (AW+1)'(HEAPS);
      base_r[0] <= ffa_pkg::RST_BASE0; base_r[1] <= ffa_pkg::RST_BASE1;
      base_r[2] <= ffa_pkg::RST_BASE2;
      hsize_r[0] <= ffa_pkg::RST_SIZE0; hsize_r[1] <= ffa_pkg::RST_SIZE1;
      hsize_r[2] <= ffa_pkg::RST_SIZE2;
      st_r <= '0; rh_r <= '0; ad_r <= '0;
    end else begin
      state_r <= state_nxt;
      heap_r <= heap_nxt;
      ov_r <= ov_nxt;
      nextd_r <= nextd_nxt;
      st_r <= st_nxt; rh_r <= rh_nxt; ad_r <= ad_nxt;
      if (head_we) head_r[head_wi[$clog2(HEAPS+1)-1:0]] <= head_wv;
      if (in_valid && !in_stall) op_r <= in_op;
      if (cfg_we) begin
        case (cfg_index)
          ffa_pkg::CFG_H0_BASE: base_r[0] <= cfg_data;
          ffa_pkg::CFG_H0_SIZE: hsize_r[0] <= cfg_data[18:0];
          ffa_pkg::CFG_H1_BASE: base_r[1] <= cfg_data;
          ffa_pkg::CFG_H1_SIZE: hsize_r[1] <= cfg_data[18:0];
          ffa_pkg::CFG_H2_BASE: base_r[2] <= cfg_data;
          ffa_pkg::CFG_H2_SIZE: hsize_r[2] <= cfg_data[18:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt; prev_r <= prev_nxt; found_r <= found_nxt; steps_r <= steps_nxt;
    faddr_r <= faddr_nxt; fsize_r <= fsize_nxt; flink_r <= flink_nxt;
    if (in_valid && !in_stall) begin
      want_r <= in_alloc_size; msz_r <= in_map_size; off_r <= in_map_offset;
      hnd_r <= in_handle;
    end
  end

  `FFA_ASSERT_IMP(a_busy_stall, clk, rst_n, state_r != ffa_pkg::S_IDLE, in_stall)
  `FFA_ASSERT_NXT(a_done_out, clk, rst_n, state_r == ffa_pkg::S_DONE, out_valid)
  `FFA_ASSERT_IMP(a_pool_bound, clk, rst_n, 1'b1, nextd_r <= NIL)
  `FFA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                  out_valid && $stable(out_status))
endmodule
